[rtl/core/pct_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pct_pkg
// Shared types and constants of the prime candidate tester.
// ----------------------------------------------------------------------------
package pct_pkg;

  localparam int DEF_TABLE_DEPTH = 64;
  localparam int DEF_VALUE_WIDTH = 16;

  localparam logic [1:0]  FIRST_CANDIDATE = 2'h2;
  localparam logic [15:0] MAX_VALUE_RESET = 16'hFFFF;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_READ,
    S_LOAD,
    S_DIV,
    S_EVAL,
    S_EMIT
  } pct_state_t;

  // controller -> datapath
  typedef struct packed {
    logic idx_clr;
    logic idx_inc;
    logic rd_en;
    logic ld_div;
    logic div_step;
    logic set_verdict;
    logic verdict_prime;
    logic verdict_fin;
    logic emit;
  } pct_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic fin;        // candidate above max_value
    logic cnt_zero;   // table empty
    logic div_last;   // last divider step this cycle
    logic p_gt_q;     // p*p > candidate
    logic rem_zero;   // p divides candidate
    logic idx_last;   // last stored prime tried
    logic out_free;   // output register can take a result
  } pct_sts_t;

endpackage

[rtl/core/pct_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pct_ram
// Generic single write port / single read port RAM, registered read.
// ----------------------------------------------------------------------------
module pct_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/pct_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pct_ctrl
// Sequencer: walks the stored primes for one candidate and issues commands.
// ----------------------------------------------------------------------------
module pct_ctrl
  import pct_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  input  logic     in_advance,
  output logic     in_tready,
  input  pct_sts_t sts,
  output pct_cmd_t cmd
);

  pct_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_advance) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (sts.fin || sts.cnt_zero) state_nxt = S_EMIT;
        else                         state_nxt = S_READ;
      end
      S_READ:  state_nxt = S_LOAD;
      S_LOAD:  state_nxt = S_DIV;
      S_DIV: begin
        if (sts.div_last) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (sts.p_gt_q || sts.rem_zero || sts.idx_last) state_nxt = S_EMIT;
        else                                            state_nxt = S_READ;
      end
      S_EMIT: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: in_tready = 1'b1;
      S_CHECK: begin
        cmd.idx_clr       = 1'b1;
        cmd.set_verdict   = 1'b1;
        cmd.verdict_fin   = sts.fin;
        cmd.verdict_prime = ~sts.fin;  // empty table: candidate two
      end
      S_READ:  cmd.rd_en    = 1'b1;
      S_LOAD:  cmd.ld_div   = 1'b1;
      S_DIV:   cmd.div_step = 1'b1;
      S_EVAL: begin
        if (sts.p_gt_q || sts.idx_last || sts.rem_zero) begin
          cmd.set_verdict   = 1'b1;
          cmd.verdict_prime = sts.p_gt_q | ~sts.rem_zero;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_EMIT:  cmd.emit = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

[rtl/core/pct_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pct_dp
// Datapath: prime table, restoring divider, candidate state, output register.
// ----------------------------------------------------------------------------
module pct_dp
  import pct_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wen,
  input  logic [VALUE_WIDTH-1:0] cfg_wdata,
  input  pct_cmd_t               cmd,
  output pct_sts_t               sts,
  input  logic                   out_tready,
  output logic                   out_valid,
  output logic [VALUE_WIDTH-1:0] out_cand,
  output logic                   out_prime,
  output logic                   out_fin
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int DW = $clog2(VALUE_WIDTH);
  localparam int VW = VALUE_WIDTH;

  logic [VW-1:0] max_r,   max_nxt;
  logic [VW:0]   cand_r,  cand_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] idx_r,   idx_nxt;
  logic [VW-1:0] p_r,     p_nxt;
  logic [VW-1:0] rem_r,   rem_nxt;
  logic [VW-1:0] quo_r,   quo_nxt;
  logic [DW-1:0] dcnt_r,  dcnt_nxt;
  logic          vprime_r, vprime_nxt;
  logic          vfin_r,   vfin_nxt;
  logic          oval_r,   oval_nxt;
  logic [VW-1:0] ocand_r,  ocand_nxt;
  logic          oprime_r, oprime_nxt;
  logic          ofin_r,   ofin_nxt;

  logic [VW-1:0] rd_data;
  logic [VW:0]   sh, diff;
  logic          ge, room, wr_en;

  assign room  = count_r < CW'(TABLE_DEPTH);
  assign wr_en = cmd.emit & ~vfin_r & vprime_r & room;

  pct_ram #(
    .WIDTH (VW),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (count_r[AW-1:0]),
    .wdata (cand_r[VW-1:0]),
    .re    (cmd.rd_en),
    .raddr (idx_r),
    .rdata (rd_data)
  );

  // one quotient bit per step
  assign sh   = {rem_r, quo_r[VW-1]};
  assign diff = sh - {1'b0, p_r};
  assign ge   = sh >= {1'b0, p_r};

  always_comb begin
    sts.fin      = cand_r > {1'b0, max_r};
    sts.cnt_zero = count_r == '0;
    sts.div_last = dcnt_r == DW'(VW - 1);
    sts.p_gt_q   = p_r > quo_r;     // p > n/p  <=>  p*p > n
    sts.rem_zero = rem_r == '0;
    sts.idx_last = (CW'(idx_r) + CW'(1)) == count_r;
    sts.out_free = ~oval_r | out_tready;
  end

  always_comb begin
    max_nxt    = max_r;
    cand_nxt   = cand_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    p_nxt      = p_r;
    rem_nxt    = rem_r;
    quo_nxt    = quo_r;
    dcnt_nxt   = dcnt_r;
    vprime_nxt = vprime_r;
    vfin_nxt   = vfin_r;
    oval_nxt   = oval_r & ~out_tready;
    ocand_nxt  = ocand_r;
    oprime_nxt = oprime_r;
    ofin_nxt   = ofin_r;

    if (cfg_wen) max_nxt = cfg_wdata;
    if (cmd.idx_clr) idx_nxt = '0;
    if (cmd.idx_inc) idx_nxt = idx_r + AW'(1);
    if (cmd.ld_div) begin
      p_nxt    = rd_data;
      rem_nxt  = '0;
      quo_nxt  = cand_r[VW-1:0];
      dcnt_nxt = '0;
    end
    if (cmd.div_step) begin
      rem_nxt  = ge ? diff[VW-1:0] : sh[VW-1:0];
      quo_nxt  = {quo_r[VW-2:0], ge};
      dcnt_nxt = dcnt_r + DW'(1);
    end
    if (cmd.set_verdict) begin
      vprime_nxt = cmd.verdict_prime;
      vfin_nxt   = cmd.verdict_fin;
    end
    if (cmd.emit) begin
      oval_nxt   = 1'b1;
      ocand_nxt  = vfin_r ? '0 : cand_r[VW-1:0];
      oprime_nxt = vprime_r & ~vfin_r;
      ofin_nxt   = vfin_r;
      if (!vfin_r) cand_nxt = cand_r + (VW+1)'(1);
      if (wr_en)   count_nxt = count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r   <= VW'(MAX_VALUE_RESET);
      cand_r  <= (VW+1)'(FIRST_CANDIDATE);
      count_r <= '0;
      oval_r  <= 1'b0;
    end else begin
      max_r   <= max_nxt;
      cand_r  <= cand_nxt;
      count_r <= count_nxt;
      oval_r  <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    p_r      <= p_nxt;
    rem_r    <= rem_nxt;
    quo_r    <= quo_nxt;
    dcnt_r   <= dcnt_nxt;
    vprime_r <= vprime_nxt;
    vfin_r   <= vfin_nxt;
    ocand_r  <= ocand_nxt;
    oprime_r <= oprime_nxt;
    ofin_r   <= ofin_nxt;
  end

  assign out_valid = oval_r;
  assign out_cand  = ocand_r;
  assign out_prime = oprime_r;
  assign out_fin   = ofin_r;

endmodule

[rtl/core/prime_candidate_tester_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prime_candidate_tester_unit
// Trial-division prime generator, one candidate tested per request with advance set.
// ----------------------------------------------------------------------------
// Usage:
//   Each request on the in_ stream with advance=1 tests the next candidate
//   (2, 3, 4, ...) and returns one result on the out_ stream: candidate and
//   is_prime in tdata, finished in tuser. Requests with advance=0 are taken
//   and dropped with no result. Once the candidate passes max_value every
//   request returns finished with candidate and is_prime at zero.
//   cfg_wen/cfg_wdata write max_value; write only while the block is idle.
// Sequence:
//   One request at a time. Stored primes p are tried in order until one
//   divides the candidate, p*p exceeds it or the table runs out; each try
//   is a table read, a divider load, VALUE_WIDTH restoring divider steps
//   and an evaluation. The worst case with 16-bit values is 55 tries (the
//   54 primes below 256, then 257 ends the walk). Finished answers skip
//   the table walk. The shared divider sets the rate.
// Reset / stall:
//   Reset sets the candidate to 2, empties the prime table (no clearing
//   pass needed) and max_value to 65535. A stalled receiver holds the
//   result in the output register; one more request is taken meanwhile and
//   its result waits until the register frees up.
// ----------------------------------------------------------------------------
module prime_candidate_tester_unit
  import pct_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // configuration: max_value
  input  logic                   cfg_wen,
  input  logic [VALUE_WIDTH-1:0] cfg_wdata,
  // request stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,   // [0] advance
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [((VALUE_WIDTH+8)/8)*8-1:0] out_tdata,  // candidate, is_prime
  output logic                   out_tuser   // [0] finished
);

  localparam int OW = ((VALUE_WIDTH + 8) / 8) * 8;

  pct_cmd_t cmd;
  pct_sts_t sts;

  logic [VALUE_WIDTH-1:0] out_cand;
  logic                   out_prime;

  pct_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_advance (in_tdata[0]),
    .in_tready  (in_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  pct_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_valid  (out_tvalid),
    .out_cand   (out_cand),
    .out_prime  (out_prime),
    .out_fin    (out_tuser)
  );

  // candidate in the low bits, is_prime above it, zero padded
  assign out_tdata = OW'({out_prime, out_cand});

`ifndef SYNTH
  // a result is only loaded when the output register can take it
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_tvalid || out_tready))
    else $error("result loaded over a pending one");

  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_tvalid)
    else $error("loaded result not presented");

  // a request with advance low causes no result
  a_noadv: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && !in_tdata[0]) |=> !cmd.emit)
    else $error("result for a request without advance");

  // finished answers carry zero payload
  a_fin_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata == '0))
    else $error("finished result with nonzero payload");
`endif

endmodule
